// ===== rtl/lltc_pkg.sv =====
// Package: shared constants and types for the LCD line timing controller
`timescale 1ns / 1ps
package lltc_pkg;
    localparam int DMG_MODEL_DEF     = 1;
    localparam int MAX_OBJECTS_DEF   = 10;
    localparam int LINE_DOTS_DEF     = 456;
    localparam int VISIBLE_LINES_DEF = 144;
    localparam int SCAN_DOTS_DEF     = 80;
    localparam int DRAW_DOTS_DEF     = 172;

    localparam int TABLE_BYTES = 160;
    localparam int STORE_BYTES = 40;
    localparam int NUM_ENTRIES = 40;
    localparam logic [9:0] DOT_MAX = 10'd1023;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SCAN   = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam logic [2:0] REG_LCD_ON   = 3'd0;
    localparam logic [2:0] REG_OBJ_ON   = 3'd1;
    localparam logic [2:0] REG_TALL     = 3'd2;
    localparam logic [2:0] REG_BGWIN_ON = 3'd3;
    localparam logic [2:0] REG_WIN_ON   = 3'd4;
    localparam logic [2:0] REG_SCROLL_X = 3'd5;
    localparam logic [2:0] REG_WINDOW_Y = 3'd6;
    localparam logic [2:0] REG_WINDOW_X = 3'd7;

    typedef struct packed {
        logic       lcd_on;
        logic       obj_on;
        logic       tall_objects;
        logic       bg_window_on;
        logic       window_on;
        logic [7:0] scroll_x;
        logic [7:0] window_y;
        logic [7:0] window_x;
    } cfg_t;
endpackage

// ===== rtl/lltc_cfg.sv =====
// Configuration register file
`timescale 1ns / 1ps
module lltc_cfg
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [3:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    output lltc_pkg::cfg_t cfg
);
    import lltc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we && !cfg_index[3])
        begin
            unique case (cfg_index[2:0])
                REG_LCD_ON:   cfg_reg.lcd_on       <= cfg_data[0];
                REG_OBJ_ON:   cfg_reg.obj_on       <= cfg_data[0];
                REG_TALL:     cfg_reg.tall_objects <= cfg_data[0];
                REG_BGWIN_ON: cfg_reg.bg_window_on <= cfg_data[0];
                REG_WIN_ON:   cfg_reg.window_on    <= cfg_data[0];
                REG_SCROLL_X: cfg_reg.scroll_x     <= cfg_data;
                REG_WINDOW_Y: cfg_reg.window_y     <= cfg_data;
                REG_WINDOW_X: cfg_reg.window_x     <= cfg_data;
                default:      cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/lcd_line_timing_controller.sv =====
// Top level: LCD line sequencer with sequenced object scan and penalty walk
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_stall  | command, dots_elapsed, address, write_data
// out      | output    | out_valid/out_stall| read_data, mode, line, vblank_irq, objects_found
// cfg      | input     | cfg_we             | cfg_index, cfg_data
// A tick with the display off goes straight to S_OUT; writes, blocked reads and
// ticks outside object scan pass through S_MEM or S_TICK; an open read adds S_POST.
// A tick in object scan walks the sprite entries (up to 40), copying each selected
// object; entry to draw adds a penalty walk over the selected objects, one per step.
// After reset a clearing pass zeroes all 160 bytes of the sprite table.
// in_stall is high while an item is in work; a finished transfer waits in the
// output register and the sequencer holds in S_OUT while that register is stalled.
module lcd_line_timing_controller
#(
    parameter int DMG_MODEL     = lltc_pkg::DMG_MODEL_DEF,
    parameter int MAX_OBJECTS   = lltc_pkg::MAX_OBJECTS_DEF,
    parameter int LINE_DOTS     = lltc_pkg::LINE_DOTS_DEF,
    parameter int VISIBLE_LINES = lltc_pkg::VISIBLE_LINES_DEF,
    parameter int SCAN_DOTS     = lltc_pkg::SCAN_DOTS_DEF,
    parameter int DRAW_DOTS     = lltc_pkg::DRAW_DOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [6:0] dots_elapsed,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [1:0] mode,
    output logic [7:0] line,
    output logic       vblank_irq,
    output logic [3:0] objects_found,
    input  logic       cfg_we,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import lltc_pkg::*;

    localparam logic [3:0] MAXO = 4'(MAX_OBJECTS);
    localparam logic [9:0] LDOTS = 10'(LINE_DOTS);
    localparam logic [7:0] VLINES = 8'(VISIBLE_LINES);
    localparam logic [7:0] LAST_LINE = 8'((VISIBLE_LINES + 10) % 256);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_TICK = 4'd2,
        S_SCAN_RD = 4'd3, S_SCAN_CHK = 4'd4, S_SCAN_CP = 4'd5, S_PEN_RD = 4'd6,
        S_PEN = 4'd7, S_PEN_END = 4'd8, S_MEM = 4'd9, S_OUT = 4'd10,
        S_POST = 4'd11;

    cfg_t cfg;
    lltc_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg));

    logic [3:0] state_reg, state_next;
    logic [9:0] dot_reg;
    logic [1:0] mode_reg;
    logic [7:0] line_reg;
    logic       en_reg, whit_reg;
    logic [3:0] tot_reg;
    logic [6:0] pen_reg;
    logic [7:0] ptr_reg;
    logic [5:0] end_reg;
    logic [1:0] cp_reg;
    logic [1:0] cmd_reg;
    logic [7:0] addr_reg, wd_reg;
    logic [9:0] old_reg;
    logic       irq_reg;
    logic [63:0] seen_reg;
    logic [7:0] acc_reg;
    logic [7:0] rd_reg;
    logic [7:0] mem_q_reg;
    logic [7:0] st_q_reg;
    logic [7:0] rd_out_reg;
    logic [1:0] mode_out_reg;
    logic [7:0] line_out_reg;
    logic       irq_out_reg;
    logic [3:0] objs_out_reg;

    logic [7:0] sprite_mem [TABLE_BYTES];
    logic [7:0] store_mem [STORE_BYTES];

    // sprite table port
    logic       sp_we;
    logic [7:0] sp_waddr, sp_raddr, sp_wdata;
    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sprite_mem[sp_waddr] <= sp_wdata;
        end
        mem_q_reg <= sprite_mem[sp_raddr];
    end

    // object store port
    logic       os_we;
    logic [5:0] os_waddr, os_raddr;
    always_ff @(posedge clk)
    begin
        if (os_we)
        begin
            store_mem[os_waddr] <= mem_q_reg;
        end
        st_q_reg <= store_mem[os_raddr];
    end

    logic in_acc;
    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    logic       out_v_reg;
    assign out_valid = out_v_reg;

    logic load_out;
    assign load_out = (state_reg == S_OUT) && (!out_v_reg || !out_stall);

    // tick arithmetic
    logic [10:0] sum;
    logic [9:0]  nd;
    assign sum = {1'b0, dot_reg} + 11'(dots_elapsed);
    assign nd  = sum[10] ? DOT_MAX : sum[9:0];

    logic [8:0] top;
    logic [7:0] y_ent;
    logic       hit;
    always_comb
    begin
        top = {1'b0, line_reg + 8'd16};
        y_ent = mem_q_reg;
        hit = ({1'b0, y_ent} <= top) &&
            ({1'b0, y_ent} + (cfg.tall_objects ? 9'd16 : 9'd8) > top);
    end

    logic win;
    assign win = (DMG_MODEL != 0) ? (cfg.bg_window_on && cfg.window_on && whit_reg)
                                  : (cfg.window_on && whit_reg);

    // penalty unit: one object per step
    logic [7:0] x, pos, xm1;
    logic       wt;
    logic [5:0] idx;
    logic [3:0] add;
    always_comb
    begin
        x = st_q_reg;
        xm1 = x - 8'd1;
        wt = win && (xm1 >= cfg.window_x);
        pos = wt ? (xm1 - cfg.window_x) : (x - 8'd8 + cfg.scroll_x);
        idx = {wt, pos[7:3]};
        add = 4'd6;
        if (x == 8'd0)
        begin
            add = 4'd11;
        end
        else if (!seen_reg[idx] && pos[2:0] < 3'd5)
        begin
            add = 4'd11 - 4'(pos[2:0]);
        end
    end

    logic [9:0] draw_end;
    assign draw_end = 10'(SCAN_DOTS) + 10'(DRAW_DOTS) + 10'(pen_reg);

    always_comb
    begin
        sp_we = 1'b0;
        sp_waddr = addr_reg;
        sp_wdata = wd_reg;
        sp_raddr = addr_reg;
        os_we = 1'b0;
        os_waddr = 6'(tot_reg) * 6'd4 + 6'(cp_reg);
        os_raddr = 6'd1;
        if (state_reg == S_CLEAR)
        begin
            sp_we = 1'b1;
            sp_waddr = ptr_reg;
            sp_wdata = 8'd0;
        end
        else if (state_reg == S_MEM && cmd_reg == CMD_WRITE && mode_reg[1] == 1'b0 &&
            addr_reg < 8'(TABLE_BYTES))
        begin
            sp_we = 1'b1;
        end
        if (state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK || state_reg == S_SCAN_CP)
        begin
            sp_raddr = {ptr_reg[5:0], 2'b00} + 8'(cp_reg);
        end
        if (state_reg == S_SCAN_CP)
        begin
            os_we = 1'b1;
            os_waddr = 6'(tot_reg) * 6'd4 + 6'(cp_reg) - 6'd1;
        end
        // prefetch the x byte of the next object
        if (state_reg == S_PEN && ptr_reg[3:0] < 4'd9)
        begin
            os_raddr = 6'(ptr_reg[3:0] + 4'd1) * 6'd4 + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            dot_reg <= '0; mode_reg <= MODE_HBLANK; line_reg <= '0;
            en_reg <= 1'b0; whit_reg <= 1'b0; tot_reg <= '0; pen_reg <= '0;
            ptr_reg <= '0; end_reg <= '0; cp_reg <= '0; cmd_reg <= CMD_TICK;
            addr_reg <= '0; wd_reg <= '0; old_reg <= '0; irq_reg <= 1'b0;
            seen_reg <= '0; acc_reg <= '0; rd_reg <= 8'hFF;
            out_v_reg <= 1'b0;
            rd_out_reg <= 8'hFF; mode_out_reg <= MODE_HBLANK; line_out_reg <= '0;
            irq_out_reg <= 1'b0; objs_out_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_v_reg <= 1'b1;
                rd_out_reg <= rd_reg;
                mode_out_reg <= mode_reg;
                line_out_reg <= line_reg;
                irq_out_reg <= irq_reg;
                objs_out_reg <= tot_reg;
            end
            else if (out_v_reg && !out_stall)
            begin
                out_v_reg <= 1'b0;
            end
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + 8'd1;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg <= command; addr_reg <= address; wd_reg <= write_data;
                        irq_reg <= 1'b0; rd_reg <= 8'hFF;
                        if (command == CMD_TICK)
                        begin
                            if (!cfg.lcd_on)
                            begin
                                if (en_reg)
                                begin
                                    en_reg <= 1'b0; line_reg <= '0;
                                    dot_reg <= '0; mode_reg <= MODE_HBLANK;
                                end
                            end
                            else
                            begin
                                en_reg <= 1'b1;
                                if (!en_reg)
                                begin
                                    mode_reg <= MODE_SCAN;
                                end
                                old_reg <= en_reg ? dot_reg : dot_reg;
                                dot_reg <= nd;
                                ptr_reg <= {1'b0, dot_reg[7:1]};
                                end_reg <= (nd[9:1] > 9'd40) ? 6'd40 : nd[6:1];
                            end
                        end
                    end
                end
                S_TICK:
                begin
                    unique case (mode_reg)
                        MODE_SCAN:
                        begin
                            cp_reg <= '0;
                            if (DMG_MODEL == 0)
                            begin
                                ptr_reg <= '0;
                                end_reg <= (dot_reg >= 10'(SCAN_DOTS)) ? 6'd40 : 6'd0;
                            end
                            else if (dot_reg[9:1] > 9'd40 && old_reg[9:1] > 9'd40)
                            begin
                                ptr_reg <= 8'd40;
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (dot_reg >= draw_end) mode_reg <= MODE_HBLANK;
                        end
                        MODE_HBLANK:
                        begin
                            if (dot_reg >= LDOTS)
                            begin
                                dot_reg <= dot_reg - LDOTS;
                                line_reg <= line_reg + 8'd1;
                                if (line_reg + 8'd1 == VLINES)
                                begin
                                    mode_reg <= MODE_VBLANK; irq_reg <= 1'b1;
                                    whit_reg <= 1'b0;
                                end
                                else
                                begin
                                    mode_reg <= MODE_SCAN; tot_reg <= '0;
                                    if (cfg.window_y == line_reg + 8'd1) whit_reg <= 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (dot_reg >= LDOTS)
                            begin
                                dot_reg <= dot_reg - LDOTS;
                                line_reg <= line_reg + 8'd1;
                                if (line_reg + 8'd1 == LAST_LINE)
                                begin
                                    mode_reg <= MODE_SCAN; tot_reg <= '0; line_reg <= '0;
                                end
                            end
                        end
                    endcase
                end
                S_SCAN_RD:
                begin
                    cp_reg <= '0;
                end
                S_SCAN_CHK:
                begin
                    if (hit)
                    begin
                        cp_reg <= 2'd1;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 8'd1;
                    end
                end
                S_SCAN_CP:
                begin
                    cp_reg <= cp_reg + 2'd1;
                    if (cp_reg == 2'd3)
                    begin
                        tot_reg <= tot_reg + 4'd1;
                        ptr_reg <= ptr_reg + 8'd1;
                    end
                end
                S_PEN_RD:
                begin
                    ptr_reg <= '0; seen_reg <= '0;
                    acc_reg <= {5'd0, cfg.scroll_x[2:0]} + (win ? 8'd6 : 8'd0);
                end
                S_PEN:
                begin
                    if (cfg.obj_on && ptr_reg[3:0] < tot_reg)
                    begin
                        acc_reg <= acc_reg + 8'(add);
                        if (x != 8'd0) seen_reg[idx] <= 1'b1;
                        ptr_reg <= ptr_reg + 8'd1;
                    end
                end
                S_PEN_END:
                begin
                    pen_reg <= acc_reg[6:0];
                    mode_reg <= MODE_DRAW;
                end
                S_MEM:
                begin
                    if (cmd_reg == CMD_READ && !mode_reg[1] && addr_reg < 8'(TABLE_BYTES))
                        rd_reg <= 8'hFF;
                end
                S_POST:
                begin
                    rd_reg <= mem_q_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    logic scan_more;
    assign scan_more = (ptr_reg < 8'(end_reg)) && (tot_reg < MAXO) && (ptr_reg < 8'd40);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    state_next = (ptr_reg == 8'(TABLE_BYTES - 1)) ? S_IDLE : S_CLEAR;
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (command == CMD_TICK)
                        state_next = cfg.lcd_on ? S_TICK : S_OUT;
                    else
                        state_next = S_MEM;
                end
            end
            S_TICK:
            begin
                if (mode_reg == MODE_SCAN)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_OUT;
            end
            S_SCAN_RD:  state_next = scan_more ? S_SCAN_CHK :
                ((dot_reg >= 10'(SCAN_DOTS)) ? S_PEN_RD : S_OUT);
            S_SCAN_CHK: state_next = hit ? S_SCAN_CP : S_SCAN_RD;
            S_SCAN_CP:  state_next = (cp_reg == 2'd3) ? S_SCAN_RD : S_SCAN_CP;
            S_PEN_RD:   state_next = S_PEN;
            S_PEN:      state_next = (cfg.obj_on && ptr_reg[3:0] < tot_reg &&
                ptr_reg[3:0] != 4'd9) ? S_PEN : S_PEN_END;
            S_PEN_END:  state_next = S_OUT;
            S_MEM:      state_next = (cmd_reg == CMD_READ && !mode_reg[1] &&
                addr_reg < 8'(TABLE_BYTES)) ? S_POST : S_OUT;
            S_POST:     state_next = S_OUT;
            S_OUT:      state_next = load_out ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    assign read_data = rd_out_reg;
    assign mode = mode_out_reg;
    assign line = line_out_reg;
    assign vblank_irq = irq_out_reg;
    assign objects_found = objs_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=>
        (out_valid && $stable({read_data, mode, line, vblank_irq, objects_found})))
        else $error("output changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n) objects_found <= MAXO)
        else $error("object count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("ready while busy");
endmodule

// ===== tb/lltc_checker.sv =====
// Checker: predicts the line sequencer results and compares each output transfer
`timescale 1ns / 1ps
module lltc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] command,
    input  logic [6:0] dots_elapsed,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] read_data,
    input  logic [1:0] mode,
    input  logic [7:0] line,
    input  logic       vblank_irq,
    input  logic [3:0] objects_found,
    input  logic       cfg_we,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending
);
    import lltc_pkg::*;

    typedef struct packed {
        logic [7:0] rd;
        logic [1:0] md;
        logic [7:0] ln;
        logic       irq;
        logic [3:0] objs;
    } line_status_t;

    cfg_t         cfg;
    logic [9:0]   dots;
    logic [1:0]   cur_md;
    logic [7:0]   cur_ln;
    logic         running;
    logic         win_hit;
    logic [3:0]   obj_cnt;
    logic [6:0]   penalty;
    logic [7:0]   oam [TABLE_BYTES];
    logic [7:0]   picked [STORE_BYTES];
    line_status_t status_q[$];

    assign pending = status_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void try_entry(input int entry);
        int top, hgt, base, y;
        top = (cur_ln + 16) & 255;
        hgt = cfg.tall_objects ? 16 : 8;
        base = (entry & 63) * 4;
        if (base + 3 >= TABLE_BYTES || obj_cnt >= MAX_OBJECTS_DEF)
            return;
        y = oam[base];
        if (top - hgt < y && y <= top) begin
            for (int i = 0; i < 4; i++)
                picked[(obj_cnt * 4 + i) % STORE_BYTES] = oam[base + i];
            obj_cnt++;
        end
    endfunction

    function automatic void draw_penalty();
        int pen, x, pos, idx;
        logic win, wt;
        logic [63:0] seen;
        pen = 0;
        seen = '0;
        win = cfg.bg_window_on && cfg.window_on && win_hit;
        if (cfg.obj_on) begin
            for (int i = 0; i < obj_cnt && i < 10; i++) begin
                x = picked[(i * 4 + 1) % STORE_BYTES];
                if (x == 0) begin
                    pen += 11;
                    continue;
                end
                wt = win && (x - 1) >= cfg.window_x;
                pos = wt ? ((x - 1 - cfg.window_x) & 255) : ((x - 8 + cfg.scroll_x) & 255);
                idx = ((pos >> 3) & 31) + (wt ? 32 : 0);
                if (!seen[idx]) begin
                    seen[idx] = 1'b1;
                    if ((pos & 7) < 5)
                        pen += 5 - (pos & 7);
                end
                pen += 6;
            end
        end
        penalty = 7'((cfg.scroll_x & 7) + (win ? 6 : 0) + pen);
    endfunction

    function automatic logic advance_dots(input int t);
        int old_d, nd, b, e;
        logic irq;
        irq = 1'b0;
        if (!cfg.lcd_on) begin
            if (running) begin
                running = 1'b0;
                cur_ln = '0;
                dots = '0;
                cur_md = MODE_HBLANK;
            end
            return 1'b0;
        end
        if (!running) begin
            running = 1'b1;
            cur_md = MODE_SCAN;
        end
        old_d = dots;
        nd = old_d + t;
        if (nd > DOT_MAX)
            nd = DOT_MAX;
        dots = 10'(nd);
        case (cur_md)
            MODE_SCAN:
            begin
                if (obj_cnt != MAX_OBJECTS_DEF) begin
                    e = nd / 2;
                    if (e > 40)
                        e = 40;
                    for (b = old_d / 2; b < e && obj_cnt < MAX_OBJECTS_DEF; b++)
                        try_entry(b);
                end
                if (dots >= SCAN_DOTS_DEF) begin
                    cur_md = MODE_DRAW;
                    draw_penalty();
                end
            end
            MODE_DRAW:
            begin
                if (dots >= SCAN_DOTS_DEF + DRAW_DOTS_DEF + penalty)
                    cur_md = MODE_HBLANK;
            end
            MODE_HBLANK:
            begin
                if (dots >= LINE_DOTS_DEF) begin
                    dots -= LINE_DOTS_DEF;
                    cur_ln++;
                    if (cur_ln == VISIBLE_LINES_DEF) begin
                        cur_md = MODE_VBLANK;
                        irq = 1'b1;
                        win_hit = 1'b0;
                    end else begin
                        cur_md = MODE_SCAN;
                        obj_cnt = '0;
                        if (cfg.window_y == cur_ln)
                            win_hit = 1'b1;
                    end
                end
            end
            default:
            begin
                if (dots >= LINE_DOTS_DEF) begin
                    dots -= LINE_DOTS_DEF;
                    cur_ln++;
                    if (cur_ln == VISIBLE_LINES_DEF + 10) begin
                        cur_md = MODE_SCAN;
                        obj_cnt = '0;
                        cur_ln = '0;
                    end
                end
            end
        endcase
        return irq;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        line_status_t s, w;
        logic open;
        if (!rst_n) begin
            cfg = '0;
            dots = '0;
            cur_md = MODE_HBLANK;
            cur_ln = '0;
            running = 1'b0;
            win_hit = 1'b0;
            obj_cnt = '0;
            penalty = '0;
            fail_count = 0;
            status_q.delete();
            for (int i = 0; i < TABLE_BYTES; i++)
                oam[i] = '0;
            for (int i = 0; i < STORE_BYTES; i++)
                picked[i] = '0;
        end else begin
            if (out_valid && !out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: output transfer with nothing expected", $time);
                    fail_count++;
                end else begin
                    w = status_q.pop_front();
                    if (read_data !== w.rd)
                        report("read_data", read_data, w.rd);
                    if (mode !== w.md)
                        report("mode", mode, w.md);
                    if (line !== w.ln)
                        report("line", line, w.ln);
                    if (vblank_irq !== w.irq)
                        report("vblank_irq", vblank_irq, w.irq);
                    if (objects_found !== w.objs)
                        report("objects_found", objects_found, w.objs);
                end
            end
            if (cfg_we && !cfg_index[3]) begin
                case (cfg_index[2:0])
                    REG_LCD_ON:   cfg.lcd_on = cfg_data[0];
                    REG_OBJ_ON:   cfg.obj_on = cfg_data[0];
                    REG_TALL:     cfg.tall_objects = cfg_data[0];
                    REG_BGWIN_ON: cfg.bg_window_on = cfg_data[0];
                    REG_WIN_ON:   cfg.window_on = cfg_data[0];
                    REG_SCROLL_X: cfg.scroll_x = cfg_data;
                    REG_WINDOW_Y: cfg.window_y = cfg_data;
                    default:      cfg.window_x = cfg_data;
                endcase
            end
            if (in_valid && !in_stall) begin
                s = '0;
                s.rd = 8'hFF;
                open = cur_md < MODE_SCAN && address < TABLE_BYTES;
                if (command == CMD_TICK)
                    s.irq = advance_dots(dots_elapsed);
                else if (command == CMD_READ && open)
                    s.rd = oam[address];
                else if (command == CMD_WRITE && open)
                    oam[address] = write_data;
                s.md = cur_md;
                s.ln = cur_ln;
                s.objs = obj_cnt;
                status_q.push_back(s);
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Testbench top: stimulus, configuration phases and verdict for the line sequencer
`timescale 1ns / 1ps
module testbench;
    import lltc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] command = CMD_TICK;
    logic [6:0] dots_elapsed = '0;
    logic [7:0] address = '0;
    logic [7:0] write_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic [1:0] mode;
    logic [7:0] line;
    logic       vblank_irq;
    logic [3:0] objects_found;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    bit         hold_off = 1'b0;

    always #5 clk = ~clk;

    lcd_line_timing_controller dut (.*);
    lltc_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
            end else if (out_valid) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (gap != 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= {1'b0, idx};
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // valid stays high into the next item when there is no gap
    task automatic send(input logic [1:0] c, input int t, input int a, input int d,
                        input bit busy);
        int gap;
        gap = busy ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11));
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        dots_elapsed <= 7'(t);
        address <= 8'(a);
        write_data <= 8'(d);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_phase(input int count, input bit busy);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send(CMD_TICK, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                               : $urandom_range(0, 80), $urandom, $urandom, busy);
            else if (r < 82)
                send(CMD_READ, 0, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                               : $urandom_range(0, 159), $urandom, busy);
            else if (r < 97)
                send(CMD_WRITE, 0, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                               : $urandom_range(0, 159),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40) : $urandom, busy);
            else
                send(2'd3, $urandom, $urandom, $urandom, busy);
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        // directed: access while off, extremes, unused command
        send(CMD_WRITE, 0, 0, 8'd16, 1'b0);
        send(CMD_WRITE, 0, 1, 8'd0, 1'b0);
        send(CMD_WRITE, 0, 4, 8'd20, 1'b0);
        send(CMD_WRITE, 0, 5, 8'd255, 1'b0);
        send(CMD_WRITE, 0, 159, 8'd170, 1'b0);
        send(CMD_WRITE, 0, 160, 8'd85, 1'b0);
        send(CMD_READ, 0, 159, 0, 1'b0);
        send(CMD_READ, 0, 160, 0, 1'b0);
        send(CMD_READ, 0, 255, 0, 1'b0);
        send(2'd3, 127, 255, 255, 1'b0);
        send(CMD_TICK, 80, 0, 0, 1'b0);
        settle();
        write_reg(REG_LCD_ON, 8'd1);
        write_reg(REG_OBJ_ON, 8'd1);
        write_reg(REG_TALL, 8'd1);
        write_reg(REG_BGWIN_ON, 8'd1);
        write_reg(REG_WIN_ON, 8'd1);
        write_reg(REG_SCROLL_X, 8'd255);
        write_reg(REG_WINDOW_Y, 8'd0);
        write_reg(REG_WINDOW_X, 8'd0);
        send(CMD_TICK, 0, 0, 0, 1'b0);
        send(CMD_READ, 0, 0, 0, 1'b0);
        send(CMD_TICK, 80, 0, 0, 1'b0);
        send(CMD_WRITE, 0, 2, 1, 1'b0);
        for (int i = 0; i < 10; i++)
            send(CMD_TICK, 127, 0, 0, 1'b0);
        random_phase(350, 1'b0);
        settle();
        write_reg(REG_LCD_ON, 8'd0);
        send(CMD_TICK, 5, 0, 0, 1'b0);
        send(CMD_TICK, 5, 0, 0, 1'b0);
        random_phase(80, 1'b0);
        settle();
        write_reg(REG_LCD_ON, 8'd1);
        write_reg(REG_TALL, 8'd0);
        write_reg(REG_SCROLL_X, 8'd0);
        write_reg(REG_WINDOW_Y, 8'd255);
        write_reg(REG_WINDOW_X, 8'd255);
        write_reg(REG_BGWIN_ON, 8'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(400, 1'b1);
        join
        settle();
        for (int p = 0; p < 3; p++) begin
            write_reg(REG_OBJ_ON, 8'($urandom_range(0, 1)));
            write_reg(REG_TALL, 8'($urandom_range(0, 1)));
            write_reg(REG_BGWIN_ON, 8'($urandom_range(0, 1)));
            write_reg(REG_WIN_ON, 8'($urandom_range(0, 1)));
            write_reg(REG_SCROLL_X, 8'($urandom));
            write_reg(REG_WINDOW_Y, 8'($urandom_range(0, 150)));
            write_reg(REG_WINDOW_X, 8'($urandom));
            random_phase(290, 1'b0);
            settle();
        end
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
